### design/cwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwg_pkg
// Shared types and constants of the curved waypoint generator.
// ----------------------------------------------------------------------------
package cwg_pkg;

  localparam int MAX_POINTS_DEF = 63;
  localparam int COORD_BITS_DEF = 12;
  localparam int IN_W           = 12;
  localparam int OUT_W          = 16;
  localparam int MINC_W         = 12;
  localparam int STEP_W         = 8;
  localparam logic [11:0] MIN_COORD_RST = 12'd0;
  localparam logic [7:0]  STEP_LEN_RST  = 8'd20;

  typedef enum logic [0:0] {
    REG_MIN_COORD = 1'b0,
    REG_STEP_LEN  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIVC,
    ST_DIVS,
    ST_TEST,
    ST_DIVL,
    ST_MUL_U,
    ST_MUL_R,
    ST_MUL_X,
    ST_MUL_Y,
    ST_EMIT,
    ST_END
  } state_t;

endpackage

### design/cwg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwg_in_if
// Request channel of the waypoint generator.
// ----------------------------------------------------------------------------
interface cwg_in_if;
  logic              valid;
  logic              ready;
  logic [11:0]       begin_x;
  logic [11:0]       begin_y;
  logic [11:0]       end_x;
  logic [11:0]       end_y;
  logic signed [11:0] curve_offset;
  modport source (output valid, begin_x, begin_y, end_x, end_y, curve_offset,
                  input ready);
  modport sink (input valid, begin_x, begin_y, end_x, end_y, curve_offset,
                output ready);
endinterface

### design/cwg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwg_out_if
// Waypoint result channel.
// ----------------------------------------------------------------------------
interface cwg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        is_end;
  logic        bends_negative;
  logic        truncated;
  modport source (output valid, point_x, point_y, is_end, bends_negative, truncated,
                  input ready);
  modport sink (input valid, point_x, point_y, is_end, bends_negative, truncated,
                output ready);
endinterface

### design/cwg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwg_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface cwg_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/curved_waypoint_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curved_waypoint_generator_unit
// Generates bent waypoints between two points with one shared divider,
// square root step and a chain of multiply states.
//
// channel  dir  payload
// req      in   begin_x begin_y end_x end_y curve_offset
// pt       out  point_x point_y is_end bends_negative truncated
// cfg      in   index data
//
// setup: square root, then the cosine and sine divisions unless the path has no length
// each waypoint: test, length division, multiplies U, R, X and Y, then emit
// reset clears the registers to min_coord 0, step_length 20; no busy sweep
// request ready only in idle; a stalled result holds the sequencer
// ----------------------------------------------------------------------------
module curved_waypoint_generator_unit #(
  parameter int MAX_POINTS = cwg_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cwg_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  cwg_in_if.sink   req,
  cwg_out_if.source pt,
  cwg_cfg_if.sink  cfg
);
  import cwg_pkg::*;

  localparam int KW = $clog2(MAX_POINTS + 1);
  localparam logic [16:0] CAP17 = ((17'd1 << (COORD_BITS + 4)) - 17'd1) > 17'hFFFF ?
                                  17'hFFFF : ((17'd1 << (COORD_BITS + 4)) - 17'd1);
  localparam logic [15:0] CAP = CAP17[15:0];

  state_t state, state_next;

  logic [11:0] min_coord;
  logic [7:0]  step_length;

  logic signed [13:0] bx, by;
  logic [11:0] ex, ey;
  logic signed [12:0] dx, dy;
  logic signed [11:0] c;
  logic        neg, trunc;
  logic [24:0] d2;
  logic [20:0] droot;
  logic signed [25:0] cq, sq;
  logic [KW-1:0] k;
  logic [19:0] len;

  // root
  logic [41:0] rv;
  logic [41:0] rres;
  logic [41:0] rbit;
  // divider
  logic [45:0] num;
  logic [21:0] rem;
  logic [5:0]  cnt;
  logic        dneg;
  logic signed [25:0] lq;
  logic signed [47:0] prod;
  logic signed [35:0] rr;
  logic signed [63:0] xv;

  logic [15:0] hx;
  logic [15:0] ox, oy;
  logic        oend;
  logic        oneg;
  logic        otrunc;
  logic        ovalid;

  wire [7:0]  s_eff = (step_length == 8'd0) ? 8'd1 : step_length;
  wire [22:0] rsub  = {rem, num[45]} - {2'b0, droot};

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign pt.valid = ovalid;
  assign pt.point_x = ox;
  assign pt.point_y = oy;
  assign pt.is_end = oend;
  assign pt.bends_negative = oneg;
  assign pt.truncated = otrunc;

  function automatic logic [15:0] to_q4(input logic signed [63:0] v,
                                        input logic [11:0] mc);
    logic signed [63:0] lo;
    logic signed [63:0] t;
    logic [35:0] r;
    begin
      lo = $signed({20'd0, mc, 32'd0});
      t = (v < lo) ? lo : v;
      r = t[63:28];
      to_q4 = (r > {20'd0, CAP}) ? CAP : r[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      min_coord <= MIN_COORD_RST;
      step_length <= STEP_LEN_RST;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_MIN_COORD: min_coord <= cfg.data;
          REG_STEP_LEN:  step_length <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (pt.valid && pt.ready) ovalid <= 1'b0;
      if (state == ST_EMIT && !ovalid) ovalid <= 1'b1;
      if (state == ST_END && !ovalid) ovalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (req.valid) begin
        bx <= $signed({2'b0, req.begin_x});
        by <= $signed({2'b0, req.begin_y});
        ex <= req.end_x;
        ey <= req.end_y;
        dx <= $signed({1'b0, req.end_x}) - $signed({1'b0, req.begin_x});
        dy <= $signed({1'b0, req.end_y}) - $signed({1'b0, req.begin_y});
        c <= req.curve_offset;
        neg <= req.curve_offset[11];
        k <= '0;
        rres <= '0;
        rbit <= 42'd1 << 40;
        cnt <= '0;
      end
      ST_SQRT: begin
        if (cnt == 6'd0) begin
          d2 <= 25'(dx * dx) + 25'(dy * dy);
          rv <= {1'b0, 25'(dx * dx) + 25'(dy * dy), 16'd0};
          trunc <= {7'd0, 25'(dx * dx) + 25'(dy * dy)} >
                   (32'(MAX_POINTS) * s_eff) * (32'(MAX_POINTS) * s_eff);
          cnt <= 6'd1;
        end else begin
          if (rv >= rres + rbit) begin
            rv <= rv - (rres + rbit);
            rres <= (rres >> 1) + rbit;
          end else begin
            rres <= rres >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit == 42'd1) begin
            cnt <= '0;
          end
        end
      end
      ST_DIVC, ST_DIVS, ST_DIVL: begin
        if (cnt == 6'd0) begin
          if (state == ST_DIVC) begin
            droot <= rres[20:0];
            num <= {9'd0, (dx[12] ? 13'(-dx) : 13'(dx)), 24'd0};
            dneg <= dx[12];
          end else if (state == ST_DIVS) begin
            num <= {9'd0, (dy[12] ? 13'(-dy) : 13'(dy)), 24'd0};
            dneg <= dy[12];
          end else begin
            num <= {2'd0, len, 24'd0};
            dneg <= 1'b0;
          end
          rem <= '0;
          cnt <= 6'd1;
        end else begin
          if (!rsub[22]) rem <= rsub[21:0];
          else rem <= {rem[20:0], num[45]};
          num <= {num[44:0], !rsub[22]};
          if (cnt == 6'd46) begin
            cnt <= '0;
            if (state == ST_DIVC)
              cq <= dneg ? -$signed({1'b0, num[23:0], !rsub[22]}) :
                           $signed({1'b0, num[23:0], !rsub[22]});
            else if (state == ST_DIVS)
              sq <= dneg ? -$signed({1'b0, num[23:0], !rsub[22]}) :
                           $signed({1'b0, num[23:0], !rsub[22]});
            else
              lq <= $signed({1'b0, num[23:0], !rsub[22]});
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
      end
      ST_TEST: len <= 20'(k) * 20'(s_eff);
      ST_MUL_U: prod <= 48'((lq - 26'sd32768) * (lq - 26'sd32768));
      ST_MUL_R: rr <= 36'(c * $signed({1'b0, 18'(18'sd65536 - $signed(prod[47:16]))}));
      ST_MUL_X: xv <= $signed({bx, 32'd0}) + 64'(cq * $signed({1'b0, len}) * 64'sd65536)
                     - 64'(sq * rr);
      ST_MUL_Y: begin
        hx <= to_q4(xv, min_coord);
        xv <= $signed({by, 32'd0}) + 64'(sq * $signed({1'b0, len}) * 64'sd65536)
              + 64'(cq * rr);
      end
      ST_EMIT: if (!ovalid) begin
        ox <= hx;
        oy <= to_q4(xv, min_coord);
        oend <= 1'b0;
        oneg <= neg;
        otrunc <= trunc;
        k <= k + KW'(1);
      end
      ST_END: if (!ovalid) begin
        ox <= ({4'd0, ex, 4'd0} > CAP17) ? CAP : {ex, 4'd0};
        oy <= ({4'd0, ey, 4'd0} > CAP17) ? CAP : {ey, 4'd0};
        oend <= 1'b1;
        oneg <= neg;
        otrunc <= trunc;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid) state_next = ST_SQRT;
      ST_SQRT:  if (cnt != 6'd0 && rbit == 42'd1)
                  state_next = (rres == 42'd0 && rv < 42'd1) ? ST_END : ST_DIVC;
      ST_DIVC:  if (cnt == 6'd46) state_next = ST_DIVS;
      ST_DIVS:  if (cnt == 6'd46) state_next = ST_TEST;
      ST_TEST:  state_next = ST_DIVL;
      ST_DIVL: begin
        if (cnt == 6'd0 && (32'(len) * 32'(len) >= {7'd0, d2} || 32'(k) >= 32'(MAX_POINTS)))
          state_next = ST_END;
        else if (cnt == 6'd46) state_next = ST_MUL_U;
      end
      ST_MUL_U: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_MUL_X;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_EMIT;
      ST_EMIT:  if (!ovalid) state_next = ST_TEST;
      ST_END:   if (!ovalid) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !pt.valid || pt.is_end) else $error("ready while points pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pt.valid && !pt.ready |=> pt.valid) else $error("result dropped");
  a_kcap: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> 32'(k) <= 32'(MAX_POINTS)) else $error("waypoint count over cap");

endmodule

### verif/cwg_path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwg_path_checker
// Watches the request, configuration and waypoint channels of the curved
// waypoint generator. Mirrors the registers, predicts the waypoint list for
// every accepted request and compares each accepted waypoint in order.
// ----------------------------------------------------------------------------
module cwg_path_checker (
  input  logic      clk,
  input  logic      rst,
  cwg_in_if         req,
  cwg_out_if        pt,
  cwg_cfg_if        cfg,
  output int        errors,
  output int        pending
);
  import cwg_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        neg;
    logic        trunc;
  } waypoint_t;

  waypoint_t  path_q[$];
  logic [11:0] min_coord;
  logic [7:0]  step_len;
  int          mismatches;

  function automatic longint root_floor(longint v);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp_q4(longint v);
    longint lo;
    longint r;
    longint cap;
    cap = (longint'(1) << (COORD_BITS_DEF + 4)) - 1;
    if (cap > 65535) cap = 65535;
    lo = longint'(min_coord) <<< 32;
    if (v < lo) v = lo;
    r = v >>> 28;
    if (r > cap) r = cap;
    return r[15:0];
  endfunction

  task automatic plan_path(input logic [11:0] bx_i, by_i, ex_i, ey_i,
                           input logic signed [11:0] c_i);
    longint bx, by, ex, ey, c, dx, dy, d2, s, lim, droot, cq, sq;
    longint len, lq, u, w, r, xv, yv, cap;
    logic   neg, trunc;
    waypoint_t wp;
    bx = bx_i; by = by_i; ex = ex_i; ey = ey_i; c = c_i;
    neg = c < 0;
    dx = ex - bx;
    dy = ey - by;
    d2 = dx * dx + dy * dy;
    s = (step_len == 0) ? 1 : step_len;
    lim = MAX_POINTS_DEF * s;
    trunc = (lim * lim) < d2;
    droot = root_floor(d2 << 16);
    cq = 0;
    sq = 0;
    if (droot > 0) begin
      cq = (dx * 16777216) / droot;
      sq = (dy * 16777216) / droot;
    end
    for (int k = 0; k < MAX_POINTS_DEF; k++) begin
      len = k * s;
      if (len * len >= d2 || droot <= 0) break;
      lq = (len << 24) / droot;
      u = lq - 32768;
      w = 65536 - (u * u) / 65536;
      r = c * w;
      xv = (bx <<< 32) + cq * len * 65536 - sq * r;
      yv = (by <<< 32) + sq * len * 65536 + cq * r;
      wp.x = clamp_q4(xv);
      wp.y = clamp_q4(yv);
      wp.last = 1'b0;
      wp.neg = neg;
      wp.trunc = trunc;
      path_q.insert(path_q.size(), wp);
    end
    cap = (longint'(1) << (COORD_BITS_DEF + 4)) - 1;
    if (cap > 65535) cap = 65535;
    xv = ex << 4;
    yv = ey << 4;
    if (xv > cap) xv = cap;
    if (yv > cap) yv = cap;
    wp.x = xv[15:0];
    wp.y = yv[15:0];
    wp.last = 1'b1;
    wp.neg = neg;
    wp.trunc = trunc;
    path_q.insert(path_q.size(), wp);
  endtask

  always @(posedge clk) begin
    waypoint_t got;
    waypoint_t want;
    if (rst) begin
      min_coord <= MIN_COORD_RST;
      step_len <= STEP_LEN_RST;
      path_q.delete();
      errors <= 0;
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MIN_COORD) min_coord <= cfg.data;
        else if (cfg.index == REG_STEP_LEN) step_len <= cfg.data[7:0];
      end
      if (req.valid && req.ready)
        plan_path(req.begin_x, req.begin_y, req.end_x, req.end_y, req.curve_offset);
      if (pt.valid && pt.ready) begin
        got = '{pt.point_x, pt.point_y, pt.is_end, pt.bends_negative, pt.truncated};
        if (path_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected waypoint x=%h y=%h end=%b", got.x, got.y, got.last);
        end else begin
          want = path_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("waypoint mismatch: expected x=%h y=%h end=%b neg=%b trunc=%b, got x=%h y=%h end=%b neg=%b trunc=%b",
                       want.x, want.y, want.last, want.neg, want.trunc,
                       got.x, got.y, got.last, got.neg, got.trunc);
          end
        end
        errors <= mismatches;
      end
    end
  end

  assign pending = path_q.size();

endmodule

### verif/tb_curved_waypoint_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_curved_waypoint_generator_unit
// Drives path requests and register writes into the waypoint generator under
// several idle and stall mixes; a checker beside the block predicts and
// compares every waypoint.
// ----------------------------------------------------------------------------
module tb_curved_waypoint_generator_unit;
  import cwg_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   idle_pct;
  int   stall_pct;

  cwg_in_if  req_if();
  cwg_out_if pt_if();
  cwg_cfg_if cfg_if();

  curved_waypoint_generator_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .pt  (pt_if.source),
    .cfg (cfg_if.sink)
  );

  cwg_path_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .pt      (pt_if),
    .cfg     (cfg_if),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    pt_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_path(input logic [11:0] bx, by, ex, ey,
                           input logic signed [11:0] c);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.begin_x <= bx;
    req_if.begin_y <= by;
    req_if.end_x <= ex;
    req_if.end_y <= ey;
    req_if.curve_offset <= c;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    @(negedge clk);
  endtask

  // end point near the start, so that most paths stay short
  function automatic logic [11:0] near(input logic [11:0] p, input int span);
    int v;
    v = int'(p) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic random_paths(input int n, input int span);
    logic [11:0] bx, by, ex, ey;
    for (int i = 0; i < n; i++) begin
      bx = 12'($urandom_range(4095));
      by = 12'($urandom_range(4095));
      if ($urandom_range(99) < 10) begin
        ex = 12'($urandom_range(4095));
        ey = 12'($urandom_range(4095));
      end else if ($urandom_range(99) < 5) begin
        ex = bx;
        ey = by;
      end else begin
        ex = near(bx, span);
        ey = near(by, span);
      end
      send_path(bx, by, ex, ey, 12'($urandom_range(4095)));
      if (i == n / 2 && $urandom_range(1)) begin
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    req_if.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.begin_x = '0;
    req_if.begin_y = '0;
    req_if.end_x = '0;
    req_if.end_y = '0;
    req_if.curve_offset = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MIN_COORD;
    cfg_if.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings
    send_path(12'd100, 12'd100, 12'd100, 12'd100, 12'sd0);
    send_path(12'd0, 12'd0, 12'd0, 12'd0, -12'sd2048);
    send_path(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'sd2047);
    send_path(12'd0, 12'd0, 12'd4095, 12'd4095, 12'sd2047);
    send_path(12'd4095, 12'd4095, 12'd0, 12'd0, -12'sd2048);
    send_path(12'd0, 12'd2000, 12'd200, 12'd2000, 12'sd50);
    send_path(12'd2000, 12'd300, 12'd2000, 12'd0, -12'sd50);
    send_path(12'd10, 12'd10, 12'd150, 12'd90, -12'sd2048);
    send_path(12'd4000, 12'd4000, 12'd4095, 12'd3900, 12'sd2047);
    send_path(12'd500, 12'd500, 12'd501, 12'd500, 12'sd7);
    req_if.valid <= 1'b0;
    write_reg(REG_STEP_LEN, 12'd1);
    send_path(12'd0, 12'd0, 12'd4095, 12'd0, 12'sd100);
    send_path(12'd40, 12'd40, 12'd45, 12'd43, -12'sd1);
    req_if.valid <= 1'b0;
    write_reg(REG_STEP_LEN, 12'd0);
    send_path(12'd300, 12'd300, 12'd310, 12'd300, 12'sd2047);
    req_if.valid <= 1'b0;
    write_reg(REG_STEP_LEN, 12'd255);
    write_reg(REG_MIN_COORD, 12'd4095);
    send_path(12'd0, 12'd0, 12'd4095, 12'd4095, -12'sd2048);
    send_path(12'd4095, 12'd0, 12'd0, 12'd4095, 12'sd2047);
    send_path(12'd100, 12'd100, 12'd100, 12'd100, 12'sd1);
    req_if.valid <= 1'b0;
    write_reg(REG_MIN_COORD, 12'd2048);
    send_path(12'd1000, 12'd3000, 12'd3000, 12'd1000, 12'sd1500);
    req_if.valid <= 1'b0;

    // random: settings, idle and stall mixes per phase
    write_reg(REG_MIN_COORD, 12'd0);
    write_reg(REG_STEP_LEN, 12'd20);
    random_paths(60, 200);
    idle_pct = 55;
    write_reg(REG_STEP_LEN, 12'd255);
    random_paths(60, 2000);
    idle_pct = 0;
    stall_pct = 55;
    write_reg(REG_MIN_COORD, 12'($urandom_range(4095)));
    write_reg(REG_STEP_LEN, 12'($urandom_range(255, 1)));
    random_paths(60, 300);
    idle_pct = 10;
    stall_pct = 10;
    write_reg(REG_MIN_COORD, 12'd4095);
    write_reg(REG_STEP_LEN, 12'd8);
    random_paths(50, 60);
    idle_pct = 55;
    stall_pct = 55;
    write_reg(REG_MIN_COORD, 12'($urandom_range(600)));
    write_reg(REG_STEP_LEN, 12'd1);
    random_paths(40, 12);
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_STEP_LEN, 12'd0);
    random_paths(30, 10);
    write_reg(REG_MIN_COORD, 12'd0);
    write_reg(REG_STEP_LEN, 12'd255);
    random_paths(30, 4095);

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
